// ----- hw/rtl/pun_pkg.sv -----
package pun_pkg;

  // fixed field widths
  localparam int SAMPLE_WIDTH = 20;
  localparam int TAP_W        = 12;
  localparam int KSIZE        = 5;
  localparam int KHALF        = 2;
  localparam int KROW_W       = KSIZE * TAP_W;
  localparam int DIM_REG_W    = 8;
  localparam int PHASE_W      = 2;
  localparam int MAX_DIM_DEF  = 128;

  // accumulator widths: at most nine present taps, so four guard bits
  localparam int PROD_W = SAMPLE_WIDTH + TAP_W;
  localparam int NUM_W  = PROD_W + 4;
  localparam int DEN_W  = TAP_W + 4;
  localparam int DIV_W  = NUM_W + 2;
  localparam int QCNT_W = $clog2(SAMPLE_WIDTH + 1);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = KROW_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KROW0  = 3'd0,
    CFG_KROW1  = 3'd1,
    CFG_KROW2  = 3'd2,
    CFG_KROW3  = 3'd3,
    CFG_KROW4  = 3'd4,
    CFG_ROWS   = 3'd5,
    CFG_COLS   = 3'd6,
    CFG_PHASE  = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAP,
    S_DRAIN,
    S_DIV,
    S_WAIT,
    S_OUT
  } state_e;

  typedef struct packed {
    logic                           mode;
    logic signed [SAMPLE_WIDTH-1:0] sample;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] pixel;
    logic                           no_weight;
    logic                           last_of_frame;
  } out_beat_t;

endpackage

// ----- hw/rtl/pun_div.sv -----
// restoring divider for the rounded quotient, one quotient bit per cycle
module pun_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [pun_pkg::DIV_W-1:0]     dividend_i,
  input  logic [pun_pkg::DEN_W:0]       divisor_i,
  output logic                          done_o,
  output logic                          ovf_o,
  output logic [pun_pkg::SAMPLE_WIDTH-1:0] quot_o
);

  localparam int SW = pun_pkg::SAMPLE_WIDTH;
  localparam int W  = pun_pkg::DIV_W;
  localparam int CW = pun_pkg::QCNT_W;

  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  dvs_q, dvs_d;
  logic [SW-1:0] quot_q, quot_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          ovf_q, ovf_d;
  logic          done_q, done_d;
  logic [W-1:0]  dvs_ext;

  assign dvs_ext = W'(divisor_i);

  // one compare and subtract per step, divisor walks down one bit
  always_comb begin
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    ovf_d  = ovf_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = dividend_i;
      dvs_d  = dvs_ext << (SW - 1);
      quot_d = '0;
      cnt_d  = CW'(SW);
      busy_d = 1'b1;
      ovf_d  = dividend_i >= (dvs_ext << SW);
    end else if (busy_q) begin
      if (rem_q >= dvs_q) begin
        rem_d  = rem_q - dvs_q;
        quot_d = {quot_q[SW-2:0], 1'b1};
      end else begin
        quot_d = {quot_q[SW-2:0], 1'b0};
      end
      dvs_d = dvs_q >> 1;
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quot_q <= quot_d;
    ovf_q  <= ovf_d;
  end

  assign done_o = done_q;
  assign ovf_o  = ovf_q;
  assign quot_o = quot_q;

endmodule

// ----- hw/rtl/pyramid_upsample_normalized_core.sv -----
// channel | direction | handshake          | payload
// in      | input     | in_valid_i/in_stall_o   | in_beat_i (mode, sample)
// out     | output    | out_valid_o/out_stall_i | out_beat_o (pixel, no_weight, last)
// cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// a store beat is written into the store as it is taken; a produce beat walks
// all 25 kernel taps, one store read and multiply-accumulate per cycle, then
// the divider, which is skipped when the weight sum is zero
// the store read port and the shared multiplier set the tap walk length
// reset is asynchronous; the store itself is not cleared
// a finished pixel sits in the output register while a new beat is taken
module pyramid_upsample_normalized_core #(
  parameter int MAX_DIM = pun_pkg::MAX_DIM_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  pun_pkg::in_beat_t               in_beat_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output pun_pkg::out_beat_t              out_beat_o,
  input  logic                            cfg_we_i,
  input  logic [pun_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pun_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int SW    = pun_pkg::SAMPLE_WIDTH;
  localparam int TW    = pun_pkg::TAP_W;
  localparam int DIM_W = $clog2(MAX_DIM);
  localparam int CNT_W = $clog2(MAX_DIM + 1);
  localparam int PW    = DIM_W + 2;
  localparam int HALF  = (MAX_DIM + 1) / 2;
  localparam int DEPTH = HALF * HALF;
  localparam int AW    = $clog2(DEPTH);
  localparam int LC_W  = $clog2(DEPTH + 1);
  localparam int HIW   = $clog2(HALF);
  localparam int HW    = $clog2(HALF + 1);
  localparam int NW    = pun_pkg::NUM_W;
  localparam int DW    = pun_pkg::DEN_W;

  // configuration registers
  logic [pun_pkg::KROW_W-1:0]    kernel_q [pun_pkg::KSIZE];
  logic [pun_pkg::DIM_REG_W-1:0] rows_reg_q, cols_reg_q;
  logic [pun_pkg::PHASE_W-1:0]   phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < pun_pkg::KSIZE; k++) begin
        kernel_q[k] <= '0;
      end
      rows_reg_q <= pun_pkg::DIM_REG_W'(128);
      cols_reg_q <= pun_pkg::DIM_REG_W'(128);
      phase_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (pun_pkg::cfg_idx_e'(cfg_idx_i))
        pun_pkg::CFG_KROW0: kernel_q[0] <= cfg_wdata_i;
        pun_pkg::CFG_KROW1: kernel_q[1] <= cfg_wdata_i;
        pun_pkg::CFG_KROW2: kernel_q[2] <= cfg_wdata_i;
        pun_pkg::CFG_KROW3: kernel_q[3] <= cfg_wdata_i;
        pun_pkg::CFG_KROW4: kernel_q[4] <= cfg_wdata_i;
        pun_pkg::CFG_ROWS:  rows_reg_q  <= cfg_wdata_i[pun_pkg::DIM_REG_W-1:0];
        pun_pkg::CFG_COLS:  cols_reg_q  <= cfg_wdata_i[pun_pkg::DIM_REG_W-1:0];
        pun_pkg::CFG_PHASE: phase_q     <= cfg_wdata_i[pun_pkg::PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped plane size and coarse row pitch
  logic [CNT_W-1:0] rows, cols;
  logic [HW-1:0]    ccols;
  logic [CNT_W:0]   ccols_full;

  always_comb begin
    if (rows_reg_q == '0) rows = CNT_W'(1);
    else if (int'(rows_reg_q) > MAX_DIM) rows = CNT_W'(MAX_DIM);
    else rows = CNT_W'(rows_reg_q);
    if (cols_reg_q == '0) cols = CNT_W'(1);
    else if (int'(cols_reg_q) > MAX_DIM) cols = CNT_W'(MAX_DIM);
    else cols = CNT_W'(cols_reg_q);
    ccols_full = ({1'b0, cols} + (CNT_W+1)'(1) - (CNT_W+1)'(phase_q[1])) >> 1;
    ccols      = HW'(ccols_full);
  end

  // control state
  pun_pkg::state_e state_q, state_d;
  logic [2:0]       ky_q, ky_d, kx_q, kx_d;
  logic [DIM_W-1:0] row_q, row_d, col_q, col_d;
  logic [LC_W-1:0]  load_q, load_d;
  logic             acc_en_q;
  logic             out_valid_q, out_valid_d;
  logic             div_start;
  logic             div_done, div_ovf;
  logic [SW-1:0]    div_quot;

  logic                 in_acc;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != pun_pkg::S_IDLE);

  // tap position and presence
  logic signed [PW-1:0] pos_i, pos_j;
  logic                 pres_i, pres_j, pres;
  logic [HIW-1:0]       ih, jh;
  logic [HIW+HW-1:0]    lin;
  logic [AW-1:0]        rd_addr;
  logic [pun_pkg::KROW_W-1:0] krow;
  logic signed [TW-1:0] tap;

  always_comb begin
    pos_i  = $signed(PW'(row_q)) + $signed(PW'(ky_q)) - $signed(PW'(pun_pkg::KHALF));
    pos_j  = $signed(PW'(col_q)) + $signed(PW'(kx_q)) - $signed(PW'(pun_pkg::KHALF));
    pres_i = !pos_i[PW-1] && (pos_i[PW-2:0] < (PW-1)'(rows)) && (pos_i[0] == phase_q[0]);
    pres_j = !pos_j[PW-1] && (pos_j[PW-2:0] < (PW-1)'(cols)) && (pos_j[0] == phase_q[1]);
    pres   = pres_i && pres_j;
    ih     = HIW'(pos_i[PW-2:1]);
    jh     = HIW'(pos_j[PW-2:1]);
    lin    = ih * ccols + (HIW+HW)'(jh);
    rd_addr = AW'(lin);
    krow   = kernel_q[ky_q];
    tap    = $signed(krow[kx_q * TW +: TW]);
  end

  // coarse store
  logic signed [SW-1:0] store_q [DEPTH];
  logic signed [SW-1:0] rd_q;
  logic signed [TW-1:0] tap_q;
  logic                 pres_q;
  logic                 st_we;

  assign st_we = in_acc && !in_beat_i.mode && (load_q < LC_W'(DEPTH));

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      store_q[load_q[AW-1:0]] <= in_beat_i.sample;
    end
    rd_q  <= store_q[rd_addr];
    tap_q <= tap;
  end

  // multiply-accumulate on the registered read
  logic signed [NW-1:0]             num_q, num_d;
  logic signed [DW-1:0]             den_q, den_d;
  logic signed [pun_pkg::PROD_W-1:0] prod;

  assign prod = tap_q * rd_q;

  always_comb begin
    num_d = num_q;
    den_d = den_q;
    if (in_acc && in_beat_i.mode) begin
      num_d = '0;
      den_d = '0;
    end else if (acc_en_q && pres_q) begin
      num_d = num_q + NW'(prod);
      den_d = den_q + DW'(tap_q);
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
  end

  // divider operands: (2|num| + |den|) / (2|den|)
  logic [NW-1:0]            an;
  logic [DW-1:0]            ad;
  logic [pun_pkg::DIV_W-1:0] dvd;
  logic                     neg, nw;

  always_comb begin
    an  = num_q[NW-1] ? NW'(-num_q) : NW'(num_q);
    ad  = den_q[DW-1] ? DW'(-den_q) : DW'(den_q);
    dvd = {1'b0, an, 1'b0} + pun_pkg::DIV_W'(ad);
    neg = num_q[NW-1] ^ den_q[DW-1];
    nw  = (den_q == '0);
  end

  pun_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd),
    .divisor_i  ({ad, 1'b0}),
    .done_o     (div_done),
    .ovf_o      (div_ovf),
    .quot_o     (div_quot)
  );

  // rounding result to saturated pixel
  logic signed [SW-1:0] pix;
  logic                 last;

  always_comb begin
    if (nw) begin
      pix = '0;
    end else if (neg) begin
      if (div_ovf || ({1'b0, div_quot} > ((SW+1)'(1) << (SW - 1)))) begin
        pix = {1'b1, {(SW-1){1'b0}}};
      end else begin
        pix = -$signed(div_quot);
      end
    end else begin
      if (div_ovf || ({1'b0, div_quot} > ((SW+1)'(1) << (SW - 1)) - (SW+1)'(1))) begin
        pix = {1'b0, {(SW-1){1'b1}}};
      end else begin
        pix = $signed(div_quot);
      end
    end
    last = ((CNT_W+1)'(row_q) + (CNT_W+1)'(1) >= (CNT_W+1)'(rows)) &&
           ((CNT_W+1)'(col_q) + (CNT_W+1)'(1) >= (CNT_W+1)'(cols));
  end

  // sequencer
  logic out_load;

  always_comb begin
    state_d     = state_q;
    ky_d        = ky_q;
    kx_d        = kx_q;
    row_d       = row_q;
    col_d       = col_q;
    load_d      = load_q;
    div_start   = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (st_we) load_d = load_q + LC_W'(1);
    unique case (state_q)
      pun_pkg::S_IDLE: begin
        if (in_acc && in_beat_i.mode) begin
          ky_d    = '0;
          kx_d    = '0;
          state_d = pun_pkg::S_TAP;
        end
      end
      pun_pkg::S_TAP: begin
        if (kx_q == 3'(pun_pkg::KSIZE - 1)) begin
          kx_d = '0;
          if (ky_q == 3'(pun_pkg::KSIZE - 1)) state_d = pun_pkg::S_DRAIN;
          else ky_d = ky_q + 3'd1;
        end else begin
          kx_d = kx_q + 3'd1;
        end
      end
      pun_pkg::S_DRAIN: state_d = pun_pkg::S_DIV;
      pun_pkg::S_DIV: begin
        if (nw) begin
          state_d = pun_pkg::S_OUT;
        end else begin
          div_start = 1'b1;
          state_d   = pun_pkg::S_WAIT;
        end
      end
      pun_pkg::S_WAIT: begin
        if (div_done) state_d = pun_pkg::S_OUT;
      end
      pun_pkg::S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = pun_pkg::S_IDLE;
          if (last) begin
            row_d  = '0;
            col_d  = '0;
            load_d = '0;
          end else if ((CNT_W+1)'(col_q) + (CNT_W+1)'(1) >= (CNT_W+1)'(cols)) begin
            col_d = '0;
            row_d = row_q + DIM_W'(1);
          end else begin
            col_d = col_q + DIM_W'(1);
          end
        end
      end
      default: state_d = pun_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pun_pkg::S_IDLE;
      ky_q        <= '0;
      kx_q        <= '0;
      row_q       <= '0;
      col_q       <= '0;
      load_q      <= '0;
      acc_en_q    <= 1'b0;
      pres_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ky_q        <= ky_d;
      kx_q        <= kx_d;
      row_q       <= row_d;
      col_q       <= col_d;
      load_q      <= load_d;
      acc_en_q    <= (state_q == pun_pkg::S_TAP);
      pres_q      <= pres;
      out_valid_q <= out_valid_d;
    end
  end

  // output register
  pun_pkg::out_beat_t out_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.pixel         <= pix;
      out_q.no_weight     <= nw;
      out_q.last_of_frame <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

`ifndef NO_ASSERTIONS
  a_load_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_q <= LC_W'(DEPTH)) else $error("load count past store depth");

  a_produce_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_beat_i.mode) |=> (state_q == pun_pkg::S_TAP))
    else $error("produce beat did not start the tap walk");

  a_noweight_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.no_weight) |-> (out_q.pixel == '0))
    else $error("pixel not zero on empty weight");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || !out_stall_i))
    else $error("held result overwritten");

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && last) |=> (row_q == '0 && col_q == '0 && load_q == '0))
    else $error("frame end did not rewind position");
`endif

endmodule
